>>> hdl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants of the UTF-16 to UTF-8 encoder: the work item
// handed from the front end to the back end, and the summary status codes.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int UNIT_W   = 16;
    localparam int LEN_W    = 24;
    localparam int CP_W     = 21;
    localparam int NBYTES_W = 3;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // upper six bits of a surrogate code unit
    localparam logic [5:0] LEAD_TAG  = 6'b110110;
    localparam logic [5:0] TRAIL_TAG = 6'b110111;

    // utf-8 byte prefixes and masks
    localparam logic [7:0] PFX_CONT  = 8'h80;
    localparam logic [7:0] PFX_TWO   = 8'hc0;
    localparam logic [7:0] PFX_THREE = 8'he0;
    localparam logic [7:0] PFX_FOUR  = 8'hf0;
    localparam logic [5:0] CONT_MASK = 6'h3f;

    localparam logic [CP_W-1:0] ONE_BYTE_MAX = CP_W'(32'h7f);
    localparam logic [CP_W-1:0] TWO_BYTE_MAX = CP_W'(32'h7ff);
    localparam logic [CP_W-1:0] SUPP_BASE    = CP_W'(32'h10000);

    // summary status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // one queued job: the data bytes of an item and an optional summary
    typedef struct packed {
        logic [3:0][7:0]       bytes;
        logic [NBYTES_W-1:0]   nbytes;
        logic                  summary;
        status_t               status;
        logic [LEN_W-1:0]      length;
    } job_t;

endpackage

>>> hdl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Front end: accepts code units, pairs surrogates, keeps the per-string
// length and status, and turns each item with a result into a job for the back end.
// ----------------------------------------------------------------------------
module u16u8_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [u16u8_pkg::LEN_W-1:0]      cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [u16u8_pkg::UNIT_W-1:0]     in_unit,
    input  logic                             in_last,
    input  logic                             q_full,
    output logic                             q_push,
    output u16u8_pkg::job_t                  q_job
);

    logic [u16u8_pkg::LEN_W-1:0] capacity_reg;
    logic [9:0]                  held_lead_reg,       held_lead_next;
    logic                        lead_waiting_reg,    lead_waiting_next;
    logic [u16u8_pkg::LEN_W-1:0] needed_reg,          needed_next;
    logic                        stopped_reg,         stopped_next;
    logic                        error_reg,           error_next;

    logic                                accept;
    logic                                is_lead, is_trail, pair, has_cp;
    logic                                err_mid, lead_new, write_ok;
    logic [u16u8_pkg::CP_W-1:0]          cp;
    logic [u16u8_pkg::NBYTES_W-1:0]      nb;
    logic [u16u8_pkg::LEN_W:0]           sum;
    logic [u16u8_pkg::LEN_W-1:0]         needed_new;
    logic                                stopped_new;
    logic                                error_new;

    // utf-8 bytes of a code point, first byte in slot 0
    function automatic logic [3:0][7:0] encode(
        input logic [u16u8_pkg::CP_W-1:0]     c,
        input logic [u16u8_pkg::NBYTES_W-1:0] n
    );
        logic [3:0][7:0] b;
        b = '0;
        case (n)
            3'd1: begin
                b[0] = c[7:0];
            end
            3'd2: begin
                b[0] = u16u8_pkg::PFX_TWO   | {3'b000, c[10:6]};
                b[1] = u16u8_pkg::PFX_CONT  | {2'b00, c[5:0]};
            end
            3'd3: begin
                b[0] = u16u8_pkg::PFX_THREE | {4'b0000, c[15:12]};
                b[1] = u16u8_pkg::PFX_CONT  | {2'b00, c[11:6]};
                b[2] = u16u8_pkg::PFX_CONT  | {2'b00, c[5:0]};
            end
            3'd4: begin
                b[0] = u16u8_pkg::PFX_FOUR  | {5'b00000, c[20:18]};
                b[1] = u16u8_pkg::PFX_CONT  | {2'b00, c[17:12] & u16u8_pkg::CONT_MASK};
                b[2] = u16u8_pkg::PFX_CONT  | {2'b00, c[11:6]};
                b[3] = u16u8_pkg::PFX_CONT  | {2'b00, c[5:0]};
            end
            default: begin
                b = '0;
            end
        endcase
        return b;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // classify the unit and work out the code point and its length
    always_comb begin
        is_lead  = (in_unit[15:10] == u16u8_pkg::LEAD_TAG);
        is_trail = (in_unit[15:10] == u16u8_pkg::TRAIL_TAG);
        pair     = lead_waiting_reg && is_trail;
        err_mid  = error_reg || (lead_waiting_reg && !is_trail);
        has_cp   = pair || (!is_lead && !is_trail);
        lead_new = !pair && is_lead;
        if (pair) begin
            cp = u16u8_pkg::SUPP_BASE + {1'b0, held_lead_reg, in_unit[9:0]};
        end else begin
            cp = {5'b00000, in_unit};
        end
        if (!has_cp) begin
            nb = 3'd0;
        end else if (pair) begin
            nb = 3'd4;
        end else if (cp <= u16u8_pkg::ONE_BYTE_MAX) begin
            nb = 3'd1;
        end else if (cp <= u16u8_pkg::TWO_BYTE_MAX) begin
            nb = 3'd2;
        end else begin
            nb = 3'd3;
        end
    end

    // running length, fit test against the capacity, new status flags
    always_comb begin
        sum         = {1'b0, needed_reg} + {{(u16u8_pkg::LEN_W-2){1'b0}}, nb};
        stopped_new = stopped_reg || (has_cp && (sum > {1'b0, capacity_reg}));
        if (!has_cp) begin
            needed_new = needed_reg;
        end else if (sum[u16u8_pkg::LEN_W]) begin
            needed_new = u16u8_pkg::LEN_MAX;
        end else begin
            needed_new = sum[u16u8_pkg::LEN_W-1:0];
        end
        write_ok  = has_cp && !stopped_new && !err_mid;
        error_new = err_mid || (is_trail && !lead_waiting_reg) || (in_last && lead_new);
    end

    // job for the back end
    always_comb begin
        q_job.bytes   = encode(cp, nb);
        q_job.nbytes  = write_ok ? nb : 3'd0;
        q_job.summary = in_last;
        if (error_new) begin
            q_job.status = u16u8_pkg::ST_INVALID;
        end else if (stopped_new) begin
            q_job.status = u16u8_pkg::ST_OVERFLOW;
        end else begin
            q_job.status = u16u8_pkg::ST_OK;
        end
        q_job.length = needed_new;
        q_push       = accept && (write_ok || in_last);
    end

    // string state update, cleared after the last unit
    always_comb begin
        held_lead_next    = held_lead_reg;
        lead_waiting_next = lead_waiting_reg;
        needed_next       = needed_reg;
        stopped_next      = stopped_reg;
        error_next        = error_reg;
        if (accept) begin
            if (in_last) begin
                held_lead_next    = '0;
                lead_waiting_next = 1'b0;
                needed_next       = '0;
                stopped_next      = 1'b0;
                error_next        = 1'b0;
            end else begin
                held_lead_next    = lead_new ? in_unit[9:0] : 10'd0;
                lead_waiting_next = lead_new;
                needed_next       = needed_new;
                stopped_next      = stopped_new;
                error_next        = error_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg     <= '0;
            held_lead_reg    <= '0;
            lead_waiting_reg <= 1'b0;
            needed_reg       <= '0;
            stopped_reg      <= 1'b0;
            error_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                capacity_reg <= cfg_wdata;
            end
            held_lead_reg    <= held_lead_next;
            lead_waiting_reg <= lead_waiting_next;
            needed_reg       <= needed_next;
            stopped_reg      <= stopped_next;
            error_reg        <= error_next;
        end
    end

endmodule

>>> hdl/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// Short job queue between front and back end; the head is shown directly.
// ----------------------------------------------------------------------------
module u16u8_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  u16u8_pkg::job_t   push_job,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output u16u8_pkg::job_t   head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    u16u8_pkg::job_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_job  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> hdl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Back end: walks the head job one result per cycle while the output is not
// stalled, data bytes first and then the summary, into the output register.
// ----------------------------------------------------------------------------
module u16u8_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               job_valid,
    input  u16u8_pkg::job_t                    job,
    output logic                               job_pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         out_byte,
    output logic                               out_summary,
    output u16u8_pkg::status_t                 out_status,
    output logic [u16u8_pkg::LEN_W-1:0]        out_length,
    output logic                               out_last
);

    logic [u16u8_pkg::NBYTES_W-1:0] idx_reg, idx_next;
    logic                           valid_reg, valid_next;
    logic [7:0]                     byte_reg,  byte_next;
    logic                           summ_reg,  summ_next;
    u16u8_pkg::status_t             status_reg, status_next;
    logic [u16u8_pkg::LEN_W-1:0]    length_reg, length_next;
    logic                           last_reg,  last_next;

    logic out_free, emit, is_data, job_done;

    assign out_free = !valid_reg || out_ready;
    assign emit     = job_valid && out_free;
    assign job_pop  = emit && job_done;

    // pick the next result of the head job
    always_comb begin
        is_data  = (idx_reg < job.nbytes);
        job_done = is_data ? ((idx_reg == job.nbytes - 1'b1) && !job.summary) : 1'b1;
        idx_next = idx_reg;
        if (emit) begin
            idx_next = job_done ? '0 : idx_reg + 1'b1;
        end
    end

    // output register
    always_comb begin
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        summ_next   = summ_reg;
        status_next = status_reg;
        length_next = length_reg;
        last_next   = last_reg;
        if (emit) begin
            valid_next = 1'b1;
            last_next  = job_done;
            if (is_data) begin
                byte_next   = job.bytes[idx_reg[1:0]];
                summ_next   = 1'b0;
                status_next = u16u8_pkg::ST_OK;
                length_next = '0;
            end else begin
                byte_next   = 8'h00;
                summ_next   = 1'b1;
                status_next = job.status;
                length_next = job.length;
            end
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        summ_reg   <= summ_next;
        status_reg <= status_next;
        length_reg <= length_next;
        last_reg   <= last_next;
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign out_summary = summ_reg;
    assign out_status  = status_reg;
    assign out_length  = length_reg;
    assign out_last    = last_reg;

endmodule

>>> hdl/utf16_to_utf8_encoder_unit.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_unit
// UTF-16 to UTF-8 encoder with per-string length and status summary.
// ----------------------------------------------------------------------------
// Input stream: one UTF-16 code unit per item on s_tdata, s_tlast marks the
// last unit of a string. Output stream: one result per item; m_tuser high
// marks the end-of-string summary (status and required length), otherwise
// m_tdata carries one UTF-8 byte. m_tlast marks the last result of an input
// item. cfg_we/cfg_wdata load the destination capacity in bytes.
// The first result of an item passes the job queue and the output register.
// The front end takes one unit per cycle while the queue has room; the back
// end sends one result per cycle while the receiver takes them, so an item
// holds the back end while its results go out, and units that give no
// result cost it nothing. The job queue (QUEUE_DEPTH entries) absorbs the
// difference; s_tready drops when it fills. A stalled receiver holds the
// output register and the queue, and the input then stops once the queue is
// full. Reset zeroes capacity, string state, queue and the output valid flag.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] code_unit
    input  logic        s_tlast,    // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [7:0] out_byte, [9:8] status, [33:10] required_length
    output logic [0:0]  m_tuser,    // [0] is_summary
    output logic        m_tlast     // end_of_run
);

    logic                        q_full, q_push, q_pop, q_not_empty;
    u16u8_pkg::job_t             push_job, head_job;
    logic [7:0]                  out_byte;
    logic                        out_summary;
    u16u8_pkg::status_t          out_status;
    logic [u16u8_pkg::LEN_W-1:0] out_length;

    // classification and string state
    u16u8_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_unit   (s_tdata),
        .in_last   (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    // job queue
    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    // byte and summary emission
    u16u8_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (q_not_empty),
        .job         (head_job),
        .job_pop     (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (out_byte),
        .out_summary (out_summary),
        .out_status  (out_status),
        .out_length  (out_length),
        .out_last    (m_tlast)
    );

    // output packing
    assign m_tdata = {6'b000000, out_length, out_status, out_byte};
    assign m_tuser = out_summary;

endmodule

>>> hdl/u16u8_checker.sv
// ----------------------------------------------------------------------------
// u16u8_checker
// Port-level checks of the encoder's output stream, bound to the top level.
// ----------------------------------------------------------------------------
module u16u8_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // a summary always closes the results of its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata[7:0] == 8'h00))
        else $error("summary not last or byte nonzero");

    // data bytes carry no status or length
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata[39:8] == 32'h0))
        else $error("data item with status or length");

    // summary status is one of the three defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[9:8] != 2'b11))
        else $error("undefined summary status");

    // nothing is offered right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind utf16_to_utf8_encoder_unit u16u8_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
